[sv/bdlp_pkg.sv]
// types, constants and register codes for the button debouncer with long press
// no dependencies
package bdlp_pkg;

  localparam int TIME_BITS     = 32;
  localparam int DBNC_BITS     = 16;
  localparam int LONG_BITS     = 16;
  localparam int BTN_BITS      = 3;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 8;

  localparam logic [DBNC_BITS-1:0] DBNC_RESET = DBNC_BITS'(20);
  localparam logic [LONG_BITS-1:0] LONG_RESET = LONG_BITS'(1000);
  localparam logic [BTN_BITS-1:0]  BTN_RESET  = '0;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_BUTTON   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    FUNC_POLL = 1'b0,
    FUNC_EDGE = 1'b1
  } func_t;

  typedef struct packed {
    logic [DBNC_BITS-1:0] debounce_time;
    logic [LONG_BITS-1:0] long_press_time;
    logic [BTN_BITS-1:0]  button_id;
  } cfg_t;

  typedef struct packed {
    func_t                func;
    logic                 pin_level;
    logic [TIME_BITS-1:0] now_ms;
  } item_t;

  typedef struct packed {
    event_t              event_res;
    logic [BTN_BITS-1:0] event_button;
    logic                held;
  } result_t;

endpackage

[sv/bdlp_cfg.sv]
// configuration registers: debounce time, long press time, button number
// depends on bdlp_pkg
module bdlp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bdlp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [bdlp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output bdlp_pkg::cfg_t                    cfg
);
  import bdlp_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DEBOUNCE: cfg_nxt.debounce_time   = cfg_wdata[DBNC_BITS-1:0];
        CFG_LONG:     cfg_nxt.long_press_time = cfg_wdata[LONG_BITS-1:0];
        CFG_BUTTON:   cfg_nxt.button_id       = cfg_wdata[BTN_BITS-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= DBNC_RESET;
      cfg_r.long_press_time <= LONG_RESET;
      cfg_r.button_id       <= BTN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/bdlp_core.sv]
// debounce and long press state with its combinational update logic
// depends on bdlp_pkg
module bdlp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  bdlp_pkg::item_t   item,
  input  bdlp_pkg::cfg_t    cfg,
  output bdlp_pkg::result_t res
);
  import bdlp_pkg::*;

  logic                 held_r, held_nxt;
  logic                 dbnc_r, dbnc_nxt;
  logic                 long_r, long_nxt;
  logic [TIME_BITS-1:0] bounce_start_r, bounce_start_nxt;
  logic [TIME_BITS-1:0] press_start_r, press_start_nxt;

  logic [TIME_BITS-1:0] bounce_el;
  logic [TIME_BITS-1:0] press_el;
  logic                 bounce_done;
  logic                 press_done;
  event_t               ev;

  assign bounce_el   = item.now_ms - bounce_start_r;
  assign press_el    = item.now_ms - press_start_r;
  assign bounce_done = bounce_el >= TIME_BITS'(cfg.debounce_time);
  assign press_done  = press_el >= TIME_BITS'(cfg.long_press_time);

  always_comb begin
    held_nxt         = held_r;
    dbnc_nxt         = dbnc_r;
    long_nxt         = long_r;
    bounce_start_nxt = bounce_start_r;
    press_start_nxt  = press_start_r;
    ev               = EV_NONE;
    if (item.func == FUNC_EDGE) begin
      if (!held_r && !dbnc_r) begin
        dbnc_nxt         = 1'b1;
        bounce_start_nxt = item.now_ms;
      end
    end else if (!held_r) begin
      if (!dbnc_r) begin
        if (!item.pin_level) begin
          dbnc_nxt         = 1'b1;
          bounce_start_nxt = item.now_ms;
        end
      end else if (!item.pin_level) begin
        if (bounce_done) begin
          dbnc_nxt        = 1'b0;
          held_nxt        = 1'b1;
          long_nxt        = 1'b0;
          press_start_nxt = item.now_ms;
        end
      end else begin
        dbnc_nxt = 1'b0;
      end
    end else begin
      if (!long_r && press_done) begin
        long_nxt = 1'b1;
        ev       = EV_LONG;
      end
      if (!dbnc_r) begin
        if (item.pin_level) begin
          dbnc_nxt         = 1'b1;
          bounce_start_nxt = item.now_ms;
        end
      end else if (item.pin_level) begin
        if (bounce_done) begin
          dbnc_nxt = 1'b0;
          held_nxt = 1'b0;
          if (!long_nxt) ev = EV_SHORT;
        end
      end else begin
        dbnc_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      dbnc_r <= 1'b0;
      long_r <= 1'b0;
    end else if (step) begin
      held_r <= held_nxt;
      dbnc_r <= dbnc_nxt;
      long_r <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      bounce_start_r <= bounce_start_nxt;
      press_start_r  <= press_start_nxt;
    end
  end

  assign res.event_res    = ev;
  assign res.event_button = (ev != EV_NONE) ? cfg.button_id : '0;
  assign res.held         = held_nxt;

endmodule

[sv/button_debounce_long_press.sv]
// top level: input register, debounce core, result register and config port
// depends on bdlp_pkg, bdlp_cfg, bdlp_core
//
//  port group  direction  request holds
//  in_*        slave      tuser: func; tdata: pin_level, now_ms
//  out_*       master     tdata: event_res, event_button, held
//  cfg_*       write      one register per write, no read-back
//
// one request per cycle while the result register is not stalled
// from acceptance to result the path is input register, state update and compare logic, result register
// synchronous reset clears flags and config to defaults, no clearing pass
// a stalled result holds the input register, which keeps taking requests once empty
module button_debounce_long_press (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bdlp_pkg::IN_DATA_BITS-1:0]   in_tdata,  // pin_level, now_ms, zero pad
  input  logic                                in_tuser,  // func
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bdlp_pkg::OUT_DATA_BITS-1:0]  out_tdata, // event_res, event_button, held, pad
  input  logic                                cfg_we,
  input  logic [bdlp_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [bdlp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import bdlp_pkg::*;

  localparam int RES_BITS = $bits(result_t);

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    in_v_r, in_v_nxt;
  result_t res;
  result_t res_r;
  logic    out_v_r, out_v_nxt;
  logic    step;
  logic    in_fire;

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bdlp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item_nxt.func      = func_t'(in_tuser);
    item_nxt.pin_level = in_tdata[0];
    item_nxt.now_ms    = in_tdata[TIME_BITS:1];
    in_v_nxt           = in_fire || (in_v_r && !step);
    out_v_nxt          = step || (out_v_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= item_nxt;
    if (step)    res_r  <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_BITS-RES_BITS){1'b0}}, res_r.held,
                       res_r.event_button, res_r.event_res};

  // a short press is only reported on release
  a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.event_res == EV_SHORT |-> !res_r.held)
    else $error("short press reported while held");

  a_no_event_no_button: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.event_res == EV_NONE |-> res_r.event_button == '0)
    else $error("button number without event");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("processed request lost");

  a_stall_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && out_v_r && !out_tready |=> in_v_r && $stable(item_r))
    else $error("input register changed under stall");

endmodule

[tb/sv/button_debounce_long_press_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for button_debounce_long_press: directed plan, then random presses
// with bounce, wrap and noise, checked against an in-bench model of the debounce flags
// depends on bdlp_pkg and the button_debounce_long_press rtl
module button_debounce_long_press_test;
  import bdlp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 210;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    func_t                func;
    logic                 pin;
    logic [TIME_BITS-1:0] now_ms;
    bit                   typed;
    result_t              want;
    logic [DBNC_BITS-1:0] dbnc;
    logic [LONG_BITS-1:0] hold;
    logic [BTN_BITS-1:0]  btn;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     in_tuser = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = CFG_DEBOUNCE;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  bit      typed_now = 1'b0;
  result_t typed_want = '0;
  bit      no_idle = 1'b0;
  int      stall_left = 0;
  int      idle_cycles = 0;
  int      mismatches = 0;

  logic [DBNC_BITS-1:0] cfg_debounce = DBNC_RESET;
  logic [LONG_BITS-1:0] cfg_hold = LONG_RESET;
  logic [BTN_BITS-1:0]  cfg_button = BTN_RESET;
  logic                 btn_held = 1'b0;
  logic                 btn_bouncing = 1'b0;
  logic [TIME_BITS-1:0] bounce_t = '0;
  logic [TIME_BITS-1:0] press_t = '0;
  logic                 long_done = 1'b0;

  result_t   pending_results[$];
  plan_row_t plan[$];

  button_debounce_long_press uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t step_button(item_t it);
    logic [TIME_BITS-1:0] since_bounce;
    logic [TIME_BITS-1:0] since_press;
    event_t               ev;
    result_t              r;
    since_bounce = it.now_ms - bounce_t;
    since_press  = it.now_ms - press_t;
    ev = EV_NONE;
    if (it.func == FUNC_EDGE) begin
      if (!btn_held && !btn_bouncing) begin
        btn_bouncing = 1'b1;
        bounce_t = it.now_ms;
      end
    end else if (!btn_held) begin
      if (!btn_bouncing) begin
        if (!it.pin_level) begin
          btn_bouncing = 1'b1;
          bounce_t = it.now_ms;
        end
      end else if (!it.pin_level) begin
        if (since_bounce >= TIME_BITS'(cfg_debounce)) begin
          btn_bouncing = 1'b0;
          btn_held = 1'b1;
          long_done = 1'b0;
          press_t = it.now_ms;
        end
      end else begin
        btn_bouncing = 1'b0;
      end
    end else begin
      if (!long_done && since_press >= TIME_BITS'(cfg_hold)) begin
        long_done = 1'b1;
        ev = EV_LONG;
      end
      if (!btn_bouncing) begin
        if (it.pin_level) begin
          btn_bouncing = 1'b1;
          bounce_t = it.now_ms;
        end
      end else if (it.pin_level) begin
        if (since_bounce >= TIME_BITS'(cfg_debounce)) begin
          btn_bouncing = 1'b0;
          btn_held = 1'b0;
          if (!long_done) ev = EV_SHORT;
        end
      end else begin
        btn_bouncing = 1'b0;
      end
    end
    r.event_res = ev;
    r.event_button = (ev != EV_NONE) ? cfg_button : '0;
    r.held = btn_held;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_time(int unsigned small_max);
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, small_max));
    endcase
  endfunction

  function automatic void add_item(func_t f, logic pin, logic [TIME_BITS-1:0] t);
    plan_row_t row;
    row = '{kind: ROW_ITEM, func: f, pin: pin, now_ms: t, typed: 1'b0, want: '0,
            dbnc: '0, hold: '0, btn: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_typed(func_t f, logic pin, logic [TIME_BITS-1:0] t,
                                    event_t ev, logic [BTN_BITS-1:0] b, logic h);
    plan_row_t row;
    row = '{kind: ROW_ITEM, func: f, pin: pin, now_ms: t, typed: 1'b1,
            want: '{event_res: ev, event_button: b, held: h},
            dbnc: '0, hold: '0, btn: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [15:0] d, logic [15:0] l, logic [BTN_BITS-1:0] b);
    plan_row_t row;
    row = '{kind: ROW_CFG, func: FUNC_POLL, pin: 1'b1, now_ms: '0, typed: 1'b0, want: '0,
            dbnc: d, hold: l, btn: b};
    plan.push_back(row);
  endfunction

  task automatic send_item(func_t f, logic pin, logic [TIME_BITS-1:0] t, bit typed,
                           result_t want);
    int unsigned gap;
    in_tvalid  <= 1'b1;
    in_tuser   <= f;
    in_tdata   <= {{(IN_DATA_BITS-TIME_BITS-1){1'b0}}, t, pin};
    typed_now  <= typed;
    typed_want <= want;
    do @(posedge clk); while (!in_tready);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] d, logic [15:0] l, logic [BTN_BITS-1:0] b);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DEBOUNCE;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_addr  <= CFG_LONG;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_addr  <= CFG_BUTTON;
    cfg_wdata <= CFG_DATA_BITS'(b);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_debounce = d;
    cfg_hold = l;
    cfg_button = b;
  endtask

  // receiver with random back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) stall_left <= pick_gap();
    end
  end

  // request and result monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t model;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.event_res    = event_t'(out_tdata[1:0]);
        got.event_button = out_tdata[4:2];
        got.held         = out_tdata[5];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.event_res != want.event_res) begin
            $display("%0t: event_res expected %0d got %0d", $time, want.event_res,
                     got.event_res);
            mismatches++;
          end
          if (got.event_button != want.event_button) begin
            $display("%0t: event_button expected %0d got %0d", $time, want.event_button,
                     got.event_button);
            mismatches++;
          end
          if (got.held != want.held) begin
            $display("%0t: held expected %0d got %0d", $time, want.held, got.held);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        model = step_button('{func: func_t'(in_tuser), pin_level: in_tdata[0],
                              now_ms: in_tdata[TIME_BITS:1]});
        pending_results.push_back(typed_now ? typed_want : model);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("button_debounce_long_press verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS-1:0] step;
    logic                 phys;
    logic                 pin;
    int unsigned          bounce_left;
    int unsigned          r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // press, bounce back, long press, wrap and short press at reset settings
    add_typed(FUNC_POLL, 1'b1, 32'd0, EV_NONE, 3'd0, 1'b0);
    add_typed(FUNC_EDGE, 1'b1, 32'd5, EV_NONE, 3'd0, 1'b0);
    add_item(FUNC_POLL, 1'b0, 32'd24);
    add_typed(FUNC_POLL, 1'b0, 32'd25, EV_NONE, 3'd0, 1'b1);
    add_typed(FUNC_EDGE, 1'b0, 32'd30, EV_NONE, 3'd0, 1'b1);
    add_item(FUNC_POLL, 1'b1, 32'd100);
    add_item(FUNC_POLL, 1'b0, 32'd110);
    add_typed(FUNC_POLL, 1'b0, 32'd1025, EV_LONG, 3'd0, 1'b1);
    add_item(FUNC_POLL, 1'b1, 32'd1030);
    add_item(FUNC_POLL, 1'b1, 32'd1050);
    add_item(FUNC_POLL, 1'b0, 32'hFFFF_FFF0);
    add_item(FUNC_POLL, 1'b0, 32'h0000_0004);
    add_item(FUNC_POLL, 1'b1, 32'd10);
    add_typed(FUNC_POLL, 1'b1, 32'd30, EV_SHORT, 3'd0, 1'b0);
    // zero debounce and zero hold time
    add_cfg(16'd0, 16'd0, 3'd7);
    add_item(FUNC_POLL, 1'b0, 32'd100);
    add_item(FUNC_POLL, 1'b0, 32'd100);
    add_typed(FUNC_POLL, 1'b1, 32'd100, EV_LONG, 3'd7, 1'b1);
    add_item(FUNC_POLL, 1'b1, 32'd100);
    // long press and release in the same poll
    add_cfg(16'd0, 16'd50, 3'd5);
    add_item(FUNC_POLL, 1'b0, 32'd200);
    add_item(FUNC_POLL, 1'b0, 32'd200);
    add_item(FUNC_POLL, 1'b1, 32'd200);
    add_typed(FUNC_POLL, 1'b1, 32'd260, EV_LONG, 3'd5, 1'b0);
    // widest timings
    add_cfg(16'hFFFF, 16'hFFFF, 3'd2);
    add_item(FUNC_POLL, 1'b0, 32'd1000);
    add_item(FUNC_POLL, 1'b0, 32'd66534);
    add_item(FUNC_POLL, 1'b0, 32'd66535);
    add_typed(FUNC_POLL, 1'b1, 32'd132070, EV_LONG, 3'd2, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_config(plan[i].dbnc, plan[i].hold, plan[i].btn);
      else send_item(plan[i].func, plan[i].pin, plan[i].now_ms, plan[i].typed, plan[i].want);
    end

    t = $urandom;
    phys = 1'b1;
    bounce_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      set_config(pick_time(30), pick_time(300), 3'($urandom_range(0, 7)));
      no_idle = (p == 2 || p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) drain();
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_item(func_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                    1'b0, '0);
        end else if (r < 14) begin
          send_item(FUNC_EDGE, 1'($urandom_range(0, 1)), t, 1'b0, '0);
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: step = $urandom_range(0, cfg_debounce / 4 + 1);
            4, 5:       step = TIME_BITS'(cfg_debounce) - 1 + $urandom_range(0, 2);
            6, 7, 8:    step = $urandom_range(0, cfg_hold / 4 + 1);
            default:    step = ($urandom_range(0, 19) == 0) ? $urandom : TIME_BITS'(cfg_hold);
          endcase
          t = t + step;
          if ($urandom_range(0, 99) < 15) begin
            phys = !phys;
            bounce_left = $urandom_range(0, 3);
          end
          if (bounce_left > 0) begin
            pin = 1'($urandom_range(0, 1));
            bounce_left--;
          end else begin
            pin = phys;
          end
          send_item(FUNC_POLL, pin, t, 1'b0, '0);
        end
      end
    end

    no_idle = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("button_debounce_long_press verification clean");
    end else begin
      $display("button_debounce_long_press verification failed");
    end
    $finish;
  end

endmodule
